// ===== rtl/core/htnli_pkg.sv =====
// Shared types and constants of the hash tree node layout index unit.
package htnli_pkg;

  // Field widths
  localparam int ML_W   = 21;   // last leaf number, signed
  localparam int DIG_W  = 7;
  localparam int EXT_W  = 8;
  localparam int LVL_W  = 5;
  localparam int IDX_W  = 20;
  localparam int NUM_W  = 22;
  localparam int OFF_W  = 30;
  localparam int NB_W   = 9;    // node size in bytes, digest plus extra
  localparam int SH_W   = 6;    // shift amounts

  // Configuration register indexes
  localparam logic [1:0] CFG_LAST_LEAF   = 2'd0;
  localparam logic [1:0] CFG_DIGEST      = 2'd1;
  localparam logic [1:0] CFG_LEAF_EXTRA  = 2'd2;

  // Lookup modes
  localparam logic [1:0] MODE_POS_TO_NUM = 2'd0;
  localparam logic [1:0] MODE_NUM_TO_POS = 2'd1;
  localparam logic [1:0] MODE_OFFSET     = 2'd2;

  typedef struct packed {
    logic [1:0]       mode;
    logic [LVL_W-1:0] node_level;
    logic [IDX_W-1:0] node_index;
    logic [NUM_W-1:0] node_number_in;
  } in_item_t;

  typedef struct packed {
    logic [NUM_W-1:0] node_number_out;
    logic [LVL_W-1:0] level_out;
    logic [IDX_W-1:0] index_out;
    logic [OFF_W-1:0] byte_offset;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic setup;
    logic step;
    logic load_out;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic done;
  } dp_sts_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOAD = 4'b0010,
    S_STEP = 4'b0100,
    S_PUSH = 4'b1000
  } state_t;

  // First storage number of a level: 2^(level+1) - 2, wrapped to NUM_W bits
  function automatic logic [NUM_W-1:0] level_start(input logic [SH_W-1:0] sh);
    level_start = (NUM_W'(1) << sh) - NUM_W'(2);
  endfunction

endpackage

// ===== rtl/core/htnli_ctrl.sv =====
// Controller state machine: sequences capture, setup, iteration and result push.
module htnli_ctrl import htnli_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Commands
  always_comb begin
    in_ready     = (state_r == S_IDLE);
    cmd.capture  = in_valid && (state_r == S_IDLE);
    cmd.setup    = (state_r == S_LOAD);
    cmd.step     = (state_r == S_STEP) && !sts.done;
    cmd.load_out = (state_r == S_PUSH) && (!out_valid_r || out_ready);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_LOAD;
      S_LOAD: state_nxt = S_STEP;
      S_STEP: if (sts.done) state_nxt = S_PUSH;
      S_PUSH: if (cmd.load_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output item valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/core/htnli_dp.sv =====
// Datapath: tree size derivation, level search and offset accumulation.
module htnli_dp import htnli_pkg::*; #(
  parameter int MAX_LEVELS = 20
) (
  input  logic             clk,
  input  logic [ML_W-1:0]  last_leaf,
  input  logic [DIG_W-1:0] digest_bytes,
  input  logic [EXT_W-1:0] leaf_extra_bytes,
  input  in_item_t         in_data,
  input  dp_cmd_t          cmd,
  output dp_sts_t          sts,
  output out_item_t        out_data
);

  localparam logic [31:0] LEAF_LIMIT = (32'd1 << MAX_LEVELS) - 32'd1;

  // Item and working registers
  logic [1:0]       mode_r;
  logic [LVL_W-1:0] lvl_in_r;
  logic [IDX_W-1:0] idx_in_r;
  logic [NUM_W-1:0] num_r;
  logic [LVL_W-1:0] top_r;
  logic [NUM_W-1:0] root_r;
  logic             hit_r;
  logic [LVL_W-1:0] l_r;
  logic [NUM_W-1:0] y_r;
  logic [OFF_W-1:0] acc_r;
  out_item_t        out_r;

  // Tree size from last_leaf: top level and root number
  logic [IDX_W-1:0] um;
  logic [LVL_W-1:0] msb;
  logic [LVL_W-1:0] top_calc;
  logic [NUM_W-1:0] root_calc;

  always_comb begin
    um = last_leaf[IDX_W-1:0];
    if ({12'd0, um} > LEAF_LIMIT) um = LEAF_LIMIT[IDX_W-1:0];
    msb = '0;
    for (int i = 0; i < IDX_W; i++) begin
      if (um[i]) msb = LVL_W'(i);
    end
    if (last_leaf[ML_W-1]) begin
      top_calc  = '0;
      root_calc = '0;
    end else begin
      top_calc  = msb + LVL_W'(1);
      root_calc = NUM_W'({um[IDX_W-1:1], 2'b00}) + NUM_W'(um[0]) + NUM_W'(1);
    end
  end

  // Offset past the root answers the end of the file
  logic past_root;
  assign past_root = (mode_r == MODE_OFFSET) && (num_r > root_calc);

  // Offset step: nodes of level l_r stored before num_r, times node size
  logic [SH_W-1:0]  sh1, sh2;
  logic [NUM_W-1:0] start_l;
  logic [NUM_W-1:0] pos;
  logic [NUM_W-1:0] quot;
  logic [NUM_W-1:0] rem;
  logic [NUM_W-1:0] cnt;
  logic [NB_W-1:0]  nbytes;
  logic [NUM_W+NB_W-1:0] prod;
  logic             off_done;

  always_comb begin
    sh1     = SH_W'(l_r) + SH_W'(1);
    sh2     = SH_W'(l_r) + SH_W'(2);
    start_l = level_start(sh1);
    pos     = num_r - start_l;
    quot    = pos >> sh2;
    rem     = pos & ((NUM_W'(1) << sh2) - NUM_W'(1));
    cnt     = {quot[NUM_W-2:0], 1'b0} + ((rem < NUM_W'(2)) ? rem : NUM_W'(2));
    nbytes  = (l_r == '0) ? (NB_W'(digest_bytes) + NB_W'(leaf_extra_bytes))
                          : NB_W'(digest_bytes);
    prod    = cnt * nbytes;
    off_done = (l_r >= top_r) || (int'(l_r) > MAX_LEVELS) || (num_r <= start_l);
  end

  // Completion per mode
  always_comb begin
    case (mode_r)
      MODE_NUM_TO_POS: sts.done = hit_r || y_r[0];
      MODE_OFFSET:     sts.done = off_done;
      default:         sts.done = 1'b1;
    endcase
  end

  // Mode 0: layout number of (level, index)
  logic [SH_W-1:0]  lsh1, lsh2;
  logic [NUM_W-1:0] layout_num;

  always_comb begin
    lsh1 = SH_W'(lvl_in_r) + SH_W'(1);
    lsh2 = SH_W'(lvl_in_r) + SH_W'(2);
    layout_num = level_start(lsh1) + (NUM_W'(idx_in_r[IDX_W-1:1]) << lsh2)
               + NUM_W'(idx_in_r[0]);
  end

  // Mode 1: index within the level found; rel reuses the offset step's pos
  logic [IDX_W-1:0] found_idx;

  always_comb begin
    found_idx = IDX_W'({quot[NUM_W-2:0], 1'b0}) | IDX_W'(pos[0]);
  end

  // Result assembly
  out_item_t res;

  always_comb begin
    res = '0;
    case (mode_r)
      MODE_POS_TO_NUM: res.node_number_out = (lvl_in_r == top_r) ? root_r : layout_num;
      MODE_NUM_TO_POS: begin
        if (hit_r) begin
          res.level_out = top_r;
        end else begin
          res.level_out = l_r;
          res.index_out = found_idx;
        end
      end
      MODE_OFFSET: res.byte_offset = acc_r;
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    // Latch the accepted item
    if (cmd.capture) begin
      mode_r   <= in_data.mode;
      lvl_in_r <= in_data.node_level;
      idx_in_r <= in_data.node_index;
      num_r    <= in_data.node_number_in;
    end
    // Derive tree size and seed the iteration
    if (cmd.setup) begin
      top_r  <= top_calc;
      root_r <= root_calc;
      l_r    <= '0;
      y_r    <= NUM_W'(({1'b0, num_r} + (NUM_W + 1)'(2)) >> 1);
      hit_r  <= (num_r >= root_calc);
      // past the root: end of file, root offset plus one digest
      acc_r  <= past_root ? OFF_W'(digest_bytes) : '0;
      if (past_root) num_r <= root_calc;
    end
    // One level per cycle
    if (cmd.step) begin
      l_r <= l_r + LVL_W'(1);
      y_r <= y_r >> 1;
      if (mode_r == MODE_OFFSET) acc_r <= acc_r + OFF_W'(prod);
    end
    if (cmd.load_out) out_r <= res;
  end

  assign out_data = out_r;

endmodule

// ===== rtl/core/hash_tree_node_layout_index.sv =====
// An accepted item passes the controller states load, step and push. Mode 0, mode 3 and mode 1
// for roots leave step at once; otherwise mode 1 walks the trailing zeros of (number+2)/2 and
// mode 2 the levels below the top. One item is in work at a time, so a new item is taken only
// after the last one is pushed; the output register lets the next item start while a result
// waits. Reset (synchronous, rst_n low) idles the controller, drops out_valid and sets last
// leaf = -1 (empty tree), digest_bytes = 32, leaf_extra_bytes = 0.
module hash_tree_node_layout_index import htnli_pkg::*; #(
  parameter int MAX_LEVELS = 20
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  in_item_t        in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output out_item_t       out_data,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [ML_W-1:0] cfg_wdata
);

  // Configuration registers
  logic [ML_W-1:0]  last_leaf_r;
  logic [DIG_W-1:0] digest_bytes_r;
  logic [EXT_W-1:0] leaf_extra_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_leaf_r    <= '1;
      digest_bytes_r <= DIG_W'(32);
      leaf_extra_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LAST_LEAF:  last_leaf_r    <= cfg_wdata;
        CFG_DIGEST:     digest_bytes_r <= cfg_wdata[DIG_W-1:0];
        CFG_LEAF_EXTRA: leaf_extra_r   <= cfg_wdata[EXT_W-1:0];
        default: ;
      endcase
    end
  end

  dp_cmd_t cmd;
  dp_sts_t sts;

  htnli_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  htnli_dp #(
    .MAX_LEVELS (MAX_LEVELS)
  ) u_dp (
    .clk              (clk),
    .last_leaf        (last_leaf_r),
    .digest_bytes     (digest_bytes_r),
    .leaf_extra_bytes (leaf_extra_r),
    .in_data          (in_data),
    .cmd              (cmd),
    .sts              (sts),
    .out_data         (out_data)
  );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the hash tree node layout index unit: directed rows, then random lookups.
module testbench;
  import htnli_pkg::*;

  // Mode code the block leaves without meaning
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int TREE_LEVELS   = 20;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 106;

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            in_valid  = 1'b0;
  logic            in_ready;
  in_item_t        in_data   = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  out_item_t       out_data;
  logic            cfg_we    = 1'b0;
  logic [1:0]      cfg_index = CFG_LAST_LEAF;
  logic [ML_W-1:0] cfg_wdata = '0;

  // Hand-typed expectation riding along with the item on the input channel
  logic      cur_typed = 1'b0;
  out_item_t cur_want  = '0;
  // No idling on either side while set
  logic      calm      = 1'b0;

  hash_tree_node_layout_index dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Tree settings as written, and the shape derived from them
  logic signed [ML_W-1:0] tree_last_leaf = '1;
  logic [DIG_W-1:0]       tree_digest    = 7'd32;
  logic [EXT_W-1:0]       tree_extra     = '0;
  int unsigned            tree_top       = 0;
  bit [63:0]              tree_root      = 0;

  typedef struct {
    in_item_t  src;
    out_item_t want;
  } lookup_t;

  lookup_t pending_lookups[$];

  int fail_count   = 0;
  int result_count = 0;
  int cfg_count    = 0;
  int cycle_count  = 0;
  int mode_seen[4] = '{0, 0, 0, 0};

  // Storage number of (level, index) with sibling pairs grouped
  function automatic bit [63:0] node_number_of(bit [63:0] level, bit [63:0] idx);
    return ((64'd1 << (level + 1)) - 64'd2) + ((idx >> 1) << (level + 2)) + (idx & 64'd1);
  endfunction

  function automatic void reshape_tree();
    bit [63:0]   um;
    int unsigned msb;
    if (tree_last_leaf < 0) begin
      tree_top  = 0;
      tree_root = 0;
    end else begin
      um  = 64'(tree_last_leaf);
      msb = 0;
      while ((um >> (msb + 1)) != 0) msb++;
      tree_top  = msb + 1;
      tree_root = node_number_of(0, um) + 64'd1;
    end
  endfunction

  // Node size on a level: leaves carry the extra bytes, the root never does
  function automatic bit [63:0] level_bytes(int unsigned level);
    if (level == tree_top) return 64'(tree_digest);
    if (level == 0) return 64'(tree_digest) + 64'(tree_extra);
    return 64'(tree_digest);
  endfunction

  // Bytes of all nodes stored before a given storage number
  function automatic bit [63:0] bytes_before(bit [63:0] number);
    bit [63:0]   sum;
    bit [63:0]   start;
    bit [63:0]   pos;
    bit [63:0]   rem;
    bit [63:0]   count;
    int unsigned lv;
    sum = 0;
    for (lv = 0; lv < tree_top && lv <= TREE_LEVELS; lv++) begin
      start = (64'd1 << (lv + 1)) - 64'd2;
      if (number <= start) break;
      pos   = number - start;
      rem   = pos & ((64'd1 << (lv + 2)) - 64'd1);
      count = 64'd2 * (pos >> (lv + 2)) + ((rem < 2) ? rem : 64'd2);
      sum   = sum + count * level_bytes(lv);
    end
    return sum;
  endfunction

  function automatic out_item_t predict_lookup(in_item_t x);
    out_item_t   r;
    bit [63:0]   num;
    bit [63:0]   full;
    bit [63:0]   y;
    bit [63:0]   rel;
    int unsigned lv;
    r   = '0;
    num = 64'(x.node_number_in);
    case (x.mode)
      MODE_POS_TO_NUM: begin
        if (x.node_level == tree_top) full = tree_root;
        else full = node_number_of(64'(x.node_level), 64'(x.node_index));
        r.node_number_out = full[NUM_W-1:0];
      end
      MODE_NUM_TO_POS: begin
        if (num >= tree_root) begin
          r.level_out = LVL_W'(tree_top);
        end else begin
          // level is the count of trailing zeros of (number+2)/2
          y  = (num + 64'd2) >> 1;
          lv = 0;
          while (y[0] == 1'b0 && lv < 40) begin
            y = y >> 1;
            lv++;
          end
          rel         = num - ((64'd1 << (lv + 1)) - 64'd2);
          r.level_out = LVL_W'(lv);
          r.index_out = IDX_W'(64'd2 * (rel >> (lv + 2)) + 64'(rel[0]));
        end
      end
      MODE_OFFSET: begin
        // past the root: end of the file
        if (num > tree_root) full = bytes_before(tree_root) + level_bytes(tree_top);
        else full = bytes_before(num);
        r.byte_offset = full[OFF_W-1:0];
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic flag_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  // Directed stimulus rows
  typedef struct {
    bit              is_cfg;
    logic [1:0]      reg_idx;
    logic [ML_W-1:0] reg_val;
    in_item_t        item;
    bit              typed;
    out_item_t       want;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic dir_row_t cfg_row(logic [1:0] idx, logic [ML_W-1:0] val);
    dir_row_t r;
    r = '{is_cfg: 1'b1, reg_idx: idx, reg_val: val, item: '0, typed: 1'b0, want: '0};
    return r;
  endfunction

  function automatic dir_row_t item_row(logic [1:0] m, int lvl, int idx, int num);
    dir_row_t r;
    r = '{is_cfg: 1'b0, reg_idx: CFG_LAST_LEAF, reg_val: '0, item: '0, typed: 1'b0, want: '0};
    r.item.mode           = m;
    r.item.node_level     = LVL_W'(lvl);
    r.item.node_index     = IDX_W'(idx);
    r.item.node_number_in = NUM_W'(num);
    return r;
  endfunction

  function automatic dir_row_t checked_row(logic [1:0] m, int lvl, int idx, int num,
                                           int n_out, int l_out, int i_out, int off);
    dir_row_t r;
    r = item_row(m, lvl, idx, num);
    r.typed                = 1'b1;
    r.want.node_number_out = NUM_W'(n_out);
    r.want.level_out       = LVL_W'(l_out);
    r.want.index_out       = IDX_W'(i_out);
    r.want.byte_offset     = OFF_W'(off);
    return r;
  endfunction

  // Random lookup, mostly well formed for the current tree
  function automatic in_item_t random_lookup();
    in_item_t    x;
    bit [63:0]   noise;
    bit [63:0]   num;
    int unsigned pick;
    int unsigned lv;
    int unsigned span;
    noise = {$urandom, $urandom};
    x     = noise[$bits(in_item_t)-1:0];
    pick  = $urandom_range(0, 99);
    lv    = $urandom_range(0, tree_top);
    span  = (tree_last_leaf < 0) ? 0 : (int'(tree_last_leaf) >> lv);
    if (pick < 28) begin
      x.mode       = MODE_POS_TO_NUM;
      x.node_level = LVL_W'(lv);
      x.node_index = IDX_W'($urandom_range(0, span));
    end else if (pick < 84) begin
      x.mode = (pick < 56) ? MODE_NUM_TO_POS : MODE_OFFSET;
      if ($urandom_range(0, 1) == 1) num = node_number_of(lv, $urandom_range(0, span));
      else num = $urandom_range(0, int'(tree_root) + 2);
      x.node_number_in = num[NUM_W-1:0];
    end
    return x;
  endfunction

  // Drivers, all entered and left at a falling edge
  task automatic send_item(input in_item_t x, input logic typed, input out_item_t want);
    while (!calm && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_data   <= x;
    cur_typed <= typed;
    cur_want  <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_lookups.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [ML_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_LAST_LEAF: begin
        tree_last_leaf = val;
        reshape_tree();
      end
      CFG_DIGEST:     tree_digest = val[DIG_W-1:0];
      CFG_LEAF_EXTRA: tree_extra  = val[EXT_W-1:0];
      default: ;
    endcase
    cfg_count++;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_setting(input int ph);
    int ml;
    case (ph % 8)
      0:       ml = $urandom_range(0, 15);
      1:       ml = $urandom_range(0, 1048575);
      2:       ml = (1 << $urandom_range(1, 20)) - 1;
      3:       ml = 1 << $urandom_range(0, 19);
      4:       ml = $urandom_range(16, 4095);
      5:       ml = -1;
      6:       ml = $urandom_range(0, 1048575);
      default: ml = $urandom_range(0, 255);
    endcase
    cfg_write(CFG_LAST_LEAF, ml[ML_W-1:0]);
    cfg_write(CFG_DIGEST, ML_W'($urandom_range(1, 64)));
    cfg_write(CFG_LEAF_EXTRA, ML_W'($urandom_range(0, 255)));
  endtask

  // Result side stalls
  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 15);
  end

  // Scoreboard: results against the oldest expectation, then new accepts
  always @(posedge clk) begin : scoreboard
    lookup_t head;
    lookup_t fresh;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        result_count++;
        if (pending_lookups.size() == 0) begin
          flag_failure($sformatf("unexpected result num %0d lvl %0d idx %0d off %0d",
                                 out_data.node_number_out, out_data.level_out,
                                 out_data.index_out, out_data.byte_offset));
        end else begin
          head = pending_lookups.pop_front();
          if (out_data.node_number_out !== head.want.node_number_out ||
              out_data.level_out !== head.want.level_out ||
              out_data.index_out !== head.want.index_out ||
              out_data.byte_offset !== head.want.byte_offset) begin
            flag_failure($sformatf(
              "mismatch mode %0d lvl %0d idx %0d num %0d: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
              head.src.mode, head.src.node_level, head.src.node_index,
              head.src.node_number_in, head.want.node_number_out, head.want.level_out,
              head.want.index_out, head.want.byte_offset, out_data.node_number_out,
              out_data.level_out, out_data.index_out, out_data.byte_offset));
          end
        end
      end
      if (in_valid && in_ready) begin
        fresh.src  = in_data;
        fresh.want = cur_typed ? cur_want : predict_lookup(in_data);
        pending_lookups.push_back(fresh);
        mode_seen[in_data.mode]++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_lookups.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    // Empty tree right after reset
    dir_rows.push_back(checked_row(MODE_POS_TO_NUM, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(checked_row(MODE_NUM_TO_POS, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(checked_row(MODE_OFFSET, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(checked_row(MODE_OFFSET, 0, 0, 5, 0, 0, 0, 32));
    dir_rows.push_back(checked_row(MODE_UNUSED, 31, 'hFFFFF, 'h3FFFFF, 0, 0, 0, 0));
    // Largest tree, 64-byte digests and the largest leaf extra
    dir_rows.push_back(cfg_row(CFG_LAST_LEAF, 21'h0FFFFF));
    dir_rows.push_back(cfg_row(CFG_DIGEST, 21'd64));
    dir_rows.push_back(cfg_row(CFG_LEAF_EXTRA, 21'd255));
    dir_rows.push_back(checked_row(MODE_POS_TO_NUM, 20, 'hABCDE, 0, 2097150, 0, 0, 0));
    dir_rows.push_back(checked_row(MODE_POS_TO_NUM, 0, 0, 'h3FFFFF, 0, 0, 0, 0));
    dir_rows.push_back(item_row(MODE_POS_TO_NUM, 31, 'hFFFFF, 0));
    dir_rows.push_back(item_row(MODE_POS_TO_NUM, 0, 'hFFFFF, 0));
    dir_rows.push_back(item_row(MODE_POS_TO_NUM, 19, 1, 0));
    dir_rows.push_back(checked_row(MODE_NUM_TO_POS, 0, 0, 'h3FFFFF, 0, 20, 0, 0));
    dir_rows.push_back(checked_row(MODE_NUM_TO_POS, 0, 0, 2097150, 0, 20, 0, 0));
    dir_rows.push_back(item_row(MODE_NUM_TO_POS, 0, 0, 2097149));
    dir_rows.push_back(item_row(MODE_NUM_TO_POS, 0, 0, 0));
    dir_rows.push_back(item_row(MODE_OFFSET, 0, 0, 'h3FFFFF));
    dir_rows.push_back(item_row(MODE_OFFSET, 0, 0, 2097150));
    dir_rows.push_back(checked_row(MODE_OFFSET, 0, 0, 1, 0, 0, 0, 319));
    // Single leaf, one-byte digests and no leaf extra
    dir_rows.push_back(cfg_row(CFG_LAST_LEAF, 21'd0));
    dir_rows.push_back(cfg_row(CFG_DIGEST, 21'd1));
    dir_rows.push_back(cfg_row(CFG_LEAF_EXTRA, 21'd0));
    dir_rows.push_back(checked_row(MODE_POS_TO_NUM, 1, 0, 0, 1, 0, 0, 0));
    dir_rows.push_back(checked_row(MODE_NUM_TO_POS, 0, 0, 1, 0, 1, 0, 0));
    dir_rows.push_back(item_row(MODE_OFFSET, 0, 0, 2));
    dir_rows.push_back(item_row(MODE_OFFSET, 0, 0, 1));
    // Negative leaf counts other than -1 give an empty tree
    dir_rows.push_back(cfg_row(CFG_LAST_LEAF, 21'h1FFFFB));
    dir_rows.push_back(checked_row(MODE_POS_TO_NUM, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(checked_row(MODE_OFFSET, 0, 0, 3, 0, 0, 0, 1));
    dir_rows.push_back(cfg_row(CFG_LAST_LEAF, 21'h100000));
    dir_rows.push_back(checked_row(MODE_NUM_TO_POS, 0, 0, 100, 0, 0, 0, 0));

    reshape_tree();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        drain();
        cfg_write(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // Random phases, each under a fresh tree setting
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      random_setting(ph);
      calm = (ph == 2);
      repeat (PHASE_ITEMS) send_item(random_lookup(), 1'b0, '0);
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("lookups: %0d pos->number, %0d number->pos, %0d offset, %0d unused mode",
             mode_seen[0], mode_seen[1], mode_seen[2], mode_seen[3]);
    $display("%0d results checked over %0d register writes, %0d failures",
             result_count, cfg_count, fail_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/htnli_pkg.sv
rtl/core/htnli_ctrl.sv
rtl/core/htnli_dp.sv
rtl/core/hash_tree_node_layout_index.sv
sim/testbench.sv
